### rtl/core/pae_pkg.sv
// Package: operation and status codes for the positional array engine.
`timescale 1ns / 1ps
package pae_pkg;

  typedef logic [2:0] op_t;
  typedef logic [2:0] status_t;

  localparam op_t OP_CLEAR  = 3'd0;
  localparam op_t OP_APPEND = 3'd1;
  localparam op_t OP_INSERT = 3'd2;
  localparam op_t OP_DELETE = 3'd3;
  localparam op_t OP_SEARCH = 3'd4;
  localparam op_t OP_SORT   = 3'd5;
  localparam op_t OP_READ   = 3'd6;

  localparam status_t STS_OK       = 3'd0;
  localparam status_t STS_EMPTY    = 3'd1;
  localparam status_t STS_BADPOS   = 3'd2;
  localparam status_t STS_NOTFOUND = 3'd3;
  localparam status_t STS_FULL     = 3'd4;

endpackage

### rtl/core/positional_array_engine_core.sv
// Positional array engine: ordered signed store; clear/append/insert/delete/search/sort/read.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+----------------------------------------------
//   in_     | in  | in_valid / in_stall  | operation, position, value
//   out_    | out | out_valid / out_stall| status, found_position, read_value,
//           |     |                      | element_count
//
// Clear, append and rejected requests go straight to the finish state; read, search,
// insert, delete and sort walk the store, sort with one compare per cycle.
// All walks go through the store (one write port, one registered read port; one of each per cycle).
// Reset clears count and control only; store contents stay undefined until written.
// in_stall is high while a request is in progress; a finished beat waits in the output
// register, and the next request is taken while it waits.
`timescale 1ns / 1ps
module positional_array_engine_core #(
  parameter int STORE_DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pae_pkg::op_t      in_operation,
  input  logic [7:0]        in_position,
  input  logic signed [31:0] in_value,
  output logic              out_valid,
  input  logic              out_stall,
  output pae_pkg::status_t  out_status,
  output logic [7:0]        out_found_position,
  output logic signed [31:0] out_read_value,
  output logic [7:0]        out_element_count
);
  import pae_pkg::*;

  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int WW = ((CW > 8) ? CW : 8) + 1;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FIN     = 4'd1;
  localparam logic [3:0] S_INS_ST  = 4'd2;
  localparam logic [3:0] S_INS     = 4'd3;
  localparam logic [3:0] S_INS_WR  = 4'd4;
  localparam logic [3:0] S_DEL_ST  = 4'd5;
  localparam logic [3:0] S_DEL     = 4'd6;
  localparam logic [3:0] S_SRCH_ST = 4'd7;
  localparam logic [3:0] S_SRCH    = 4'd8;
  localparam logic [3:0] S_SORT_I  = 4'd9;
  localparam logic [3:0] S_SORT_IC = 4'd10;
  localparam logic [3:0] S_SORT_J  = 4'd11;
  localparam logic [3:0] S_SORT_WB = 4'd12;
  localparam logic [3:0] S_RD_ST   = 4'd13;
  localparam logic [3:0] S_RD      = 4'd14;

  logic [31:0] store_mem [STORE_DEPTH];
  logic [31:0] mem_rdata_r;
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0] mem_wdata;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    pos_r, pos_nxt;
  logic [31:0]   val_r, val_nxt;
  logic [31:0]   cur_r, cur_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [AW-1:0] rq_r;
  status_t       st_r, st_nxt;
  logic [7:0]    found_r, found_nxt;
  logic [31:0]   rdv_r, rdv_nxt;

  logic          out_valid_r;
  status_t       out_status_r;
  logic [7:0]    out_found_r;
  logic [31:0]   out_rdv_r;
  logic [7:0]    out_count_r;

  logic          in_acc, out_free;
  logic [CW-1:0] nm1, rq_cw, i_cw;
  logic [WW-1:0] n_w, n_p1_w, pin_w, pos_w, pos_m1_w, rq_w, rq_p1_w, cnt_w;
  logic [AW-1:0] rq_p1, rq_m1;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign nm1      = count_r - CW'(1);
  assign rq_cw    = CW'(rq_r);
  assign i_cw     = CW'(i_r);
  assign n_w      = WW'(count_r);
  assign n_p1_w   = n_w + WW'(1);
  assign pin_w    = WW'(in_position);
  assign pos_w    = WW'(pos_r);
  assign pos_m1_w = pos_w - WW'(1);
  assign rq_w     = WW'(rq_r);
  assign rq_p1_w  = rq_w + WW'(1);
  assign cnt_w    = WW'(count_r);
  assign rq_p1    = rq_r + AW'(1);
  assign rq_m1    = rq_r - AW'(1);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    cur_nxt   = cur_r;
    i_nxt     = i_r;
    st_nxt    = st_r;
    found_nxt = found_r;
    rdv_nxt   = rdv_r;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = val_r;
    mem_raddr = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          pos_nxt   = in_position;
          val_nxt   = in_value;
          st_nxt    = STS_OK;
          found_nxt = '0;
          rdv_nxt   = '0;
          i_nxt     = '0;
          state_nxt = S_FIN;
          case (in_operation)
            OP_CLEAR: count_nxt = '0;
            OP_APPEND: begin
              if (count_r == CW'(STORE_DEPTH)) begin
                st_nxt = STS_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_r[AW-1:0];
                mem_wdata = in_value;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_INSERT: begin
              if (count_r == '0) st_nxt = STS_EMPTY;
              else if (in_position == '0 || pin_w > n_p1_w) st_nxt = STS_BADPOS;
              else if (count_r == CW'(STORE_DEPTH)) st_nxt = STS_FULL;
              else if (pin_w == n_p1_w) state_nxt = S_INS_WR;
              else state_nxt = S_INS_ST;
            end
            OP_DELETE: begin
              if (count_r == '0) st_nxt = STS_EMPTY;
              else if (in_position == '0 || pin_w > n_w) st_nxt = STS_BADPOS;
              else if (pin_w == n_w) count_nxt = nm1;
              else state_nxt = S_DEL_ST;
            end
            OP_SEARCH: begin
              if (count_r == '0) st_nxt = STS_EMPTY;
              else state_nxt = S_SRCH_ST;
            end
            OP_SORT: begin
              if (count_r == '0) st_nxt = STS_EMPTY;
              else if (count_r != CW'(1)) state_nxt = S_SORT_I;
            end
            OP_READ: begin
              if (count_r == '0) st_nxt = STS_EMPTY;
              else if (in_position == '0 || pin_w > n_w) st_nxt = STS_BADPOS;
              else state_nxt = S_RD_ST;
            end
            default: ;
          endcase
        end
      end
      S_FIN: begin
        if (out_free) state_nxt = S_IDLE;
      end
      S_INS_ST: begin
        mem_raddr = nm1[AW-1:0];
        state_nxt = S_INS;
      end
      S_INS: begin
        mem_we    = 1'b1;
        mem_waddr = rq_p1;
        mem_wdata = mem_rdata_r;
        mem_raddr = rq_m1;
        if (rq_w == pos_m1_w) state_nxt = S_INS_WR;
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos_m1_w[AW-1:0];
        mem_wdata = val_r;
        count_nxt = count_r + CW'(1);
        state_nxt = S_FIN;
      end
      S_DEL_ST: begin
        mem_raddr = pos_w[AW-1:0];
        state_nxt = S_DEL;
      end
      S_DEL: begin
        mem_we    = 1'b1;
        mem_waddr = rq_m1;
        mem_wdata = mem_rdata_r;
        mem_raddr = rq_p1;
        if (rq_cw == nm1) begin
          count_nxt = nm1;
          state_nxt = S_FIN;
        end
      end
      S_SRCH_ST: begin
        mem_raddr = '0;
        state_nxt = S_SRCH;
      end
      S_SRCH: begin
        mem_raddr = rq_p1;
        if (mem_rdata_r == val_r) begin
          found_nxt = rq_p1_w[7:0];
          state_nxt = S_FIN;
        end else if (rq_cw == nm1) begin
          st_nxt    = STS_NOTFOUND;
          state_nxt = S_FIN;
        end
      end
      S_SORT_I: begin
        mem_raddr = i_r;
        state_nxt = S_SORT_IC;
      end
      S_SORT_IC: begin
        cur_nxt   = mem_rdata_r;
        mem_raddr = i_r + AW'(1);
        state_nxt = S_SORT_J;
      end
      S_SORT_J: begin
        mem_raddr = rq_p1;
        if ($signed(cur_r) > $signed(mem_rdata_r)) begin
          mem_we    = 1'b1;
          mem_waddr = rq_r;
          mem_wdata = cur_r;
          cur_nxt   = mem_rdata_r;
        end
        if (rq_cw == nm1) state_nxt = S_SORT_WB;
      end
      S_SORT_WB: begin
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = cur_r;
        i_nxt     = i_r + AW'(1);
        if (i_cw + CW'(2) == count_r) state_nxt = S_FIN;
        else state_nxt = S_SORT_I;
      end
      S_RD_ST: begin
        mem_raddr = pos_m1_w[AW-1:0];
        state_nxt = S_RD;
      end
      S_RD: begin
        rdv_nxt   = mem_rdata_r;
        state_nxt = S_FIN;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) store_mem[mem_waddr] <= mem_wdata;
    mem_rdata_r <= store_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == S_FIN && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pos_r   <= pos_nxt;
    val_r   <= val_nxt;
    cur_r   <= cur_nxt;
    i_r     <= i_nxt;
    rq_r    <= mem_raddr;
    st_r    <= st_nxt;
    found_r <= found_nxt;
    rdv_r   <= rdv_nxt;
    if (state_r == S_FIN && out_free) begin
      out_status_r <= st_r;
      out_found_r  <= found_r;
      out_rdv_r    <= rdv_r;
      out_count_r  <= cnt_w[7:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_position = out_found_r;
  assign out_read_value     = out_rdv_r;
  assign out_element_count  = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STORE_DEPTH))
    else $error("entry count beyond store depth");

  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && (state_r == S_INS || state_r == S_DEL || state_r == S_SORT_J))
      |-> (mem_waddr != mem_raddr))
    else $error("store read and write hit the same entry");

  a_sort_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SORT_J || state_r == S_SORT_WB || state_r == S_SRCH)
      |=> $stable(count_r))
    else $error("count changed during sort or search");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found_position != '0) |-> (out_status == STS_OK))
    else $error("found position with non-ok status");

  a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_free) |=> (out_valid && state_r == S_IDLE))
    else $error("finished request did not reach the output register");

endmodule
